### src/scfc_pkg.sv
package scfc_pkg;

    // frame position counter width
    localparam int INDEX_BITS = 10;
    localparam int LEN_BITS   = INDEX_BITS + 1;

    // frame constants
    localparam logic [7:0]  HDR0      = 8'hAA;
    localparam logic [7:0]  HDR1      = 8'h55;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam int          MIN_FRAME = 6;

    // configuration port
    localparam int         CFG_IDX_BITS         = 1;
    localparam int         CFG_DATA_BITS        = 8;
    localparam logic [0:0] REG_CRC_CHECK_ENABLE = 1'd0;
    localparam logic [0:0] REG_PAYLOAD_LIMIT    = 1'd1;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // verdict codes
    localparam logic [2:0] VERDICT_OK         = 3'd0;
    localparam logic [2:0] VERDICT_TOO_SHORT  = 3'd1;
    localparam logic [2:0] VERDICT_BAD_HEADER = 3'd2;
    localparam logic [2:0] VERDICT_CRC_ERROR  = 3'd3;
    localparam logic [2:0] VERDICT_LEN_ERROR  = 3'd4;

    // command queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    // work handed from the front to the back for one input word
    typedef struct packed {
        logic       has_payload;
        logic [7:0] payload;
        logic       has_verdict;
        logic [7:0] status;
        logic [2:0] verdict;
        logic [7:0] copied;
    } cmd_t;

    // one byte through the reflected crc-16, eight bit steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### src/serial_frame_checker_crc16.sv
// channel   direction  handshake             word
// -------   ---------  --------------------  ---------------------------------------------
// in        input      in_valid / in_ready   rx_byte, frame_end
// out       output     out_valid / out_ready item_kind, out_byte, verdict, copied_len,
//                                            last_of_run
// cfg       input      cfg_write             cfg_index, cfg_data
//
// one input word per cycle while the four-entry command queue has room
// each input word gives zero to two output words; the output reg sends one a cycle if out_ready
// a result is offered at the earliest after the queue and then the output reg have taken it
// reset clears frame state, the queue and the output register; no clearing pass
// a stalled output fills the queue, then in_ready drops until the back drains it
module serial_frame_checker_crc16 (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [scfc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [scfc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            rx_byte,
    input  logic                                  frame_end,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  item_kind,
    output logic [7:0]                            out_byte,
    output logic [2:0]                            verdict,
    output logic [7:0]                            copied_len,
    output logic                                  last_of_run
);
    import scfc_pkg::*;

    logic q_full;
    logic q_not_empty;
    logic q_push;
    logic q_pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // frame tracking, crc and classification
    scfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .frame_end (frame_end),
        .q_full    (q_full),
        .push      (q_push),
        .push_cmd  (push_cmd)
    );

    // command queue
    scfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // result sequencing and output register
    scfc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .not_empty   (q_not_empty),
        .head_cmd    (head_cmd),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .item_kind   (item_kind),
        .out_byte    (out_byte),
        .verdict     (verdict),
        .copied_len  (copied_len),
        .last_of_run (last_of_run)
    );

endmodule

### src/scfc_front.sv
module scfc_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [scfc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [scfc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            rx_byte,
    input  logic                                  frame_end,
    input  logic                                  q_full,
    output logic                                  push,
    output scfc_pkg::cmd_t                        push_cmd
);
    import scfc_pkg::*;

    localparam logic [INDEX_BITS-1:0] IDX_MAX   = {INDEX_BITS{1'b1}};
    localparam logic [INDEX_BITS-1:0] IDX_ONE   = INDEX_BITS'(1);
    localparam logic [INDEX_BITS-1:0] IDX_TWO   = INDEX_BITS'(2);
    localparam logic [INDEX_BITS-1:0] IDX_THREE = INDEX_BITS'(3);
    localparam logic [INDEX_BITS-1:0] IDX_FOUR  = INDEX_BITS'(4);
    localparam logic [INDEX_BITS-1:0] IDX_PAY   = INDEX_BITS'(MIN_FRAME);
    localparam logic [LEN_BITS-1:0]   LEN_MIN   = LEN_BITS'(MIN_FRAME);

    logic                  crc_en_reg;
    logic [7:0]            limit_reg;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic                  hdr_good_reg, hdr_good_next;
    logic [7:0]            status_reg, status_next;
    logic [7:0]            len_reg, len_next;
    logic [15:0]           crc_reg, crc_next;
    logic [7:0]            dly0_reg, dly1_reg;
    logic [7:0]            sent_reg, sent_next;

    logic                  take;
    logic                  send;
    logic [INDEX_BITS-1:0] pay_pos;
    logic [LEN_BITS-1:0]   flen;
    logic [LEN_BITS-1:0]   need_len;
    logic [2:0]            verd;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    // header, status and length capture
    always_comb
    begin
        hdr_good_next = hdr_good_reg;
        if (idx_reg == '0 && rx_byte != HDR0)
        begin
            hdr_good_next = 1'b0;
        end
        if (idx_reg == IDX_ONE && rx_byte != HDR1)
        begin
            hdr_good_next = 1'b0;
        end
        status_next = (idx_reg == IDX_TWO) ? rx_byte : status_reg;
        len_next    = (idx_reg == IDX_THREE) ? rx_byte : len_reg;
    end

    // crc over the byte leaving the two-deep delay line
    assign crc_next = (idx_reg >= IDX_FOUR) ? crc_feed(crc_reg, dly0_reg) : crc_reg;

    // payload release
    assign pay_pos   = idx_reg - IDX_PAY;
    assign send      = (idx_reg >= IDX_PAY) &&
                       (pay_pos < {{(INDEX_BITS-8){1'b0}}, len_reg}) &&
                       (sent_reg < limit_reg);
    assign sent_next = sent_reg + {7'd0, send};

    // verdict, checks in priority order
    assign flen     = {1'b0, idx_reg} + LEN_BITS'(1);
    assign need_len = LEN_MIN + {{(LEN_BITS-8){1'b0}}, len_next};
    always_comb
    begin
        if (flen < LEN_MIN)
        begin
            verd = VERDICT_TOO_SHORT;
        end
        else if (!hdr_good_next)
        begin
            verd = VERDICT_BAD_HEADER;
        end
        else if (crc_en_reg && ({dly1_reg, rx_byte} != crc_next))
        begin
            verd = VERDICT_CRC_ERROR;
        end
        else if (flen < need_len)
        begin
            verd = VERDICT_LEN_ERROR;
        end
        else
        begin
            verd = VERDICT_OK;
        end
    end

    // command to the queue
    always_comb
    begin
        push                 = take && (send || frame_end);
        push_cmd.has_payload = send;
        push_cmd.payload     = dly0_reg;
        push_cmd.has_verdict = frame_end;
        push_cmd.status      = status_next;
        push_cmd.verdict     = verd;
        push_cmd.copied      = (verd == VERDICT_OK) ? sent_next : 8'd0;
    end

    assign idx_next = (idx_reg != IDX_MAX) ? idx_reg + IDX_ONE : idx_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_en_reg <= 1'b1;
            limit_reg  <= 8'hFF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CRC_CHECK_ENABLE: crc_en_reg <= cfg_data[0];
                REG_PAYLOAD_LIMIT:    limit_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            hdr_good_reg <= 1'b1;
            status_reg   <= 8'd0;
            len_reg      <= 8'd0;
            crc_reg      <= CRC_INIT;
            dly0_reg     <= 8'd0;
            dly1_reg     <= 8'd0;
            sent_reg     <= 8'd0;
        end
        else if (take)
        begin
            if (frame_end)
            begin
                idx_reg      <= '0;
                hdr_good_reg <= 1'b1;
                status_reg   <= 8'd0;
                len_reg      <= 8'd0;
                crc_reg      <= CRC_INIT;
                dly0_reg     <= 8'd0;
                dly1_reg     <= 8'd0;
                sent_reg     <= 8'd0;
            end
            else
            begin
                idx_reg      <= idx_next;
                hdr_good_reg <= hdr_good_next;
                status_reg   <= status_next;
                len_reg      <= len_next;
                crc_reg      <= crc_next;
                dly0_reg     <= dly1_reg;
                dly1_reg     <= rx_byte;
                sent_reg     <= sent_next;
            end
        end
    end

`ifndef SYNTHESIS
    // a frame end restarts the position count
    assert property (@(posedge clk) disable iff (!rst_n)
        take && frame_end |=> idx_reg == '0)
        else $error("frame position not cleared after frame end");

    // payload count never passes the limit in force
    assert property (@(posedge clk) disable iff (!rst_n)
        push && push_cmd.has_payload |-> sent_reg < limit_reg)
        else $error("payload released beyond limit");
`endif

endmodule

### src/scfc_queue.sv
module scfc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scfc_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output scfc_pkg::cmd_t  head_cmd
);
    import scfc_pkg::*;

    cmd_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;

    assign full      = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_BITS'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_BITS'(1);
            end
        end
    end

`ifndef SYNTHESIS
    // no write into a full queue, no read from an empty one
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !not_empty))
        else $error("queue overflow or underflow");
`endif

endmodule

### src/scfc_back.sv
module scfc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            not_empty,
    input  scfc_pkg::cmd_t  head_cmd,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            item_kind,
    output logic [7:0]      out_byte,
    output logic [2:0]      verdict,
    output logic [7:0]      copied_len,
    output logic            last_of_run
);
    import scfc_pkg::*;

    logic       valid_reg;
    logic       pay_done_reg;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic [2:0] verd_reg;
    logic [7:0] copied_reg;
    logic       last_reg;
    logic       load;
    logic       emit_pay;

    // output register takes a new word when empty or being drained
    assign load     = not_empty && (!valid_reg || out_ready);
    assign emit_pay = head_cmd.has_payload && !pay_done_reg;
    assign pop      = load && (!emit_pay || !head_cmd.has_verdict);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            pay_done_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg    <= 1'b1;
                pay_done_reg <= emit_pay && head_cmd.has_verdict;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (emit_pay)
            begin
                kind_reg   <= KIND_PAYLOAD;
                byte_reg   <= head_cmd.payload;
                verd_reg   <= VERDICT_OK;
                copied_reg <= 8'd0;
                last_reg   <= !head_cmd.has_verdict;
            end
            else
            begin
                kind_reg   <= KIND_VERDICT;
                byte_reg   <= head_cmd.status;
                verd_reg   <= head_cmd.verdict;
                copied_reg <= head_cmd.copied;
                last_reg   <= 1'b1;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign item_kind   = kind_reg;
    assign out_byte    = byte_reg;
    assign verdict     = verd_reg;
    assign copied_len  = copied_reg;
    assign last_of_run = last_reg;

`ifndef SYNTHESIS
    // a payload word carries no verdict and no count
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && kind_reg == KIND_PAYLOAD |-> verd_reg == VERDICT_OK && copied_reg == 8'd0)
        else $error("payload word with verdict fields set");

    // a verdict word always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && kind_reg == KIND_VERDICT |-> last_reg)
        else $error("verdict word not last of run");
`endif

endmodule
